// ===== rtl/tmp_pkg.sv =====
// ----------------------------------------------------------------------------
// Tribonacci matrix power package
// Shared state encoding and constants for the matrix power block.
// ----------------------------------------------------------------------------
package tmp_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_WAIT,
        ST_STORE,
        ST_NEXT,
        ST_DONE
    } t_state;

    // Register index of the modulus.
    localparam logic [0:0] REG_MODULUS = 1'b0;

    // Reset value of the modulus.
    localparam logic [31:0] MODULUS_RESET = 32'd1000000009;

endpackage

// ===== rtl/tmp_modmul.sv =====
// ----------------------------------------------------------------------------
// Bit-serial modular multiply-accumulate
// Computes (acc + x*y) mod m: the product is built one multiplier bit per
// cycle, MSB first, and the addend joins it in the last step.
// ----------------------------------------------------------------------------
module tmp_modmul #(
    parameter int W = 30
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_acc,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_res
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_x, n_x;
    logic [W-1:0]  r_y, n_y;
    logic [W-1:0]  r_r, n_r;
    logic [W-1:0]  r_a, n_a;
    logic [W-1:0]  r_c, n_c;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [W+1:0]  dbl, dbl2, add;
    logic [W-1:0]  step;
    logic [W+1:0]  fin;

    // Reduce a value known to be below twice the modulus.
    function automatic logic [W-1:0] red(input logic [W+1:0] v, input logic [W-1:0] m);
        logic [W+1:0] d;
        d = v - {2'b00, m};
        red = (v >= {2'b00, m}) ? d[W-1:0] : v[W-1:0];
    endfunction

    // One Horner step: r = 2r + bit*x, each term reduced.
    always_comb begin
        dbl  = {1'b0, r_r, 1'b0};
        dbl2 = {2'b00, red(dbl, r_a)};
        add  = dbl2 + (r_y[W-1] ? {2'b00, r_x} : '0);
        step = red(add, r_a);
        // The addend is folded in after the last product bit.
        fin  = {2'b00, step} + {2'b00, r_c};
        n_x = r_x; n_y = r_y; n_r = r_r; n_a = r_a; n_c = r_c;
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        if (i_start) begin
            // The multiplicand and the addend are reduced first, they may equal m when m is tiny.
            n_x = red({2'b00, i_x}, i_m);
            n_y = i_y;
            n_r = '0;
            n_c = red({2'b00, i_acc}, i_m);
            n_a = i_m;
            n_cnt = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_r = step;
            n_y = {r_y[W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_r = red(fin, r_a);
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_r <= n_r;
        r_a <= n_a;
        r_c <= n_c;
    end

    assign o_done = r_done;
    assign o_res  = r_r;
endmodule

// ===== rtl/tribonacci_mod_matrix_power_top.sv =====
// ----------------------------------------------------------------------------
// Tribonacci term modulo m by 3x3 matrix power
// Square-and-multiply over a shared bit-serial modular MAC.
// ----------------------------------------------------------------------------
// A transaction is taken when i_start is high and o_busy is low. The result
// appears on o_term_value for one cycle with o_valid; it cannot be stalled.
// Each matrix product is 27 MACs on the one serial multiplier, plus a store
// state per entry and a state to commit the matrix. An index n needs one
// product per set bit of n-1 and one squaring per bit above its lowest, up
// to 124 products for the widest index. Index zero, index one and a modulus
// below two skip the products: the sequencer goes from idle straight to its
// done state, and the strobe is registered from that state.
module tribonacci_mod_matrix_power_top #(
    parameter int INDEX_BITS = 63,
    parameter int MOD_BITS   = 30
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [INDEX_BITS-1:0] i_term_index,
    output logic                  o_busy,
    output logic                  o_valid,
    output logic [MOD_BITS-1:0]   o_term_value,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    localparam int W = MOD_BITS;

    tmp_pkg::t_state r_state, n_state;
    logic [W-1:0]          r_mod;
    logic [INDEX_BITS-1:0] r_p, n_p;
    logic [W-1:0]          r_acc [9];
    logic [W-1:0]          r_sq  [9];
    logic [W-1:0]          r_res [9];
    logic                  r_is_sq, n_is_sq;
    logic [1:0]            r_i, r_j, r_k, n_i, n_j, n_k;
    logic [W-1:0]          r_sum;
    logic                  r_valid;
    logic [W-1:0]          r_out;
    logic                  mac_start, mac_done;
    logic [W-1:0]          mac_res, x_op, y_op;
    logic [3:0]            ik, kj, ij;
    logic                  last_k, last_ij;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tmp_pkg::REG_MODULUS) ? 32'(r_mod) : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= W'(tmp_pkg::MODULUS_RESET);
        end else if (psel && penable && pwrite && paddr[2] == tmp_pkg::REG_MODULUS) begin
            r_mod <= pwdata[W-1:0];
        end
    end

    // Operand selection.
    assign ik = 4'(r_i) * 4'd3 + 4'(r_k);
    assign kj = 4'(r_k) * 4'd3 + 4'(r_j);
    assign ij = 4'(r_i) * 4'd3 + 4'(r_j);
    assign x_op = r_is_sq ? r_sq[ik] : r_acc[ik];
    assign y_op = r_sq[kj];
    assign last_k  = (r_k == 2'd2);
    assign last_ij = (r_i == 2'd2) && (r_j == 2'd2);

    tmp_modmul #(.W(W)) u_mac (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mac_start),
        .i_acc(r_sum), .i_x(x_op), .i_y(y_op), .i_m(r_mod),
        .o_done(mac_done), .o_res(mac_res)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        n_p = r_p; n_is_sq = r_is_sq;
        n_i = r_i; n_j = r_j; n_k = r_k;
        case (r_state)
            tmp_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_p = i_term_index - 1'b1;
                    n_state = (i_term_index < INDEX_BITS'(2) || r_mod < W'(2))
                        ? tmp_pkg::ST_DONE : tmp_pkg::ST_LOAD;
                end
            end
            tmp_pkg::ST_LOAD: begin
                n_i = '0; n_j = '0; n_k = '0;
                if (r_p[0]) begin
                    n_is_sq = 1'b0;
                end else begin
                    // An even exponent skips the multiply and squares first.
                    n_p = r_p >> 1;
                    n_is_sq = 1'b1;
                end
                n_state = tmp_pkg::ST_MAC;
            end
            tmp_pkg::ST_MAC: n_state = tmp_pkg::ST_WAIT;
            tmp_pkg::ST_WAIT: begin
                if (mac_done) begin
                    if (last_k) begin
                        n_k = '0;
                        n_state = tmp_pkg::ST_STORE;
                    end else begin
                        n_k = r_k + 1'b1;
                        n_state = tmp_pkg::ST_MAC;
                    end
                end
            end
            tmp_pkg::ST_STORE: begin
                if (last_ij) begin
                    n_state = tmp_pkg::ST_NEXT;
                end else begin
                    n_state = tmp_pkg::ST_MAC;
                    if (r_j == 2'd2) begin
                        n_j = '0;
                        n_i = r_i + 1'b1;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            tmp_pkg::ST_NEXT: begin
                n_i = '0; n_j = '0;
                if (!r_is_sq) begin
                    // Multiply done; square next unless the exponent is spent.
                    n_p = r_p >> 1;
                    n_is_sq = 1'b1;
                    n_state = ((r_p >> 1) == '0) ? tmp_pkg::ST_DONE : tmp_pkg::ST_MAC;
                end else begin
                    // Square done; multiply if the new low bit is set.
                    if (r_p[0]) begin
                        n_is_sq = 1'b0;
                        n_state = tmp_pkg::ST_MAC;
                    end else begin
                        n_p = r_p >> 1;
                        n_state = ((r_p >> 1) == '0) ? tmp_pkg::ST_DONE : tmp_pkg::ST_MAC;
                    end
                end
            end
            tmp_pkg::ST_DONE: n_state = tmp_pkg::ST_IDLE;
            default: n_state = tmp_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        mac_start = (r_state == tmp_pkg::ST_MAC);
        o_busy = (r_state != tmp_pkg::ST_IDLE);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmp_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == tmp_pkg::ST_DONE);
        end
        r_p <= n_p; r_is_sq <= n_is_sq;
        r_i <= n_i; r_j <= n_j; r_k <= n_k;
    end

    // Matrix storage and result register.
    always_ff @(posedge i_clk) begin
        if (r_state == tmp_pkg::ST_IDLE && i_start) begin
            for (int e = 0; e < 9; e++) begin
                r_acc[e] <= (e % 4 == 0) ? W'(1) : '0;
                r_sq[e]  <= (e == 0 || e == 1 || e == 2 || e == 3 || e == 7) ? W'(1) : '0;
            end
        end
        if (r_state == tmp_pkg::ST_LOAD || r_state == tmp_pkg::ST_STORE
            || r_state == tmp_pkg::ST_NEXT) begin
            r_sum <= '0;
        end else if (r_state == tmp_pkg::ST_WAIT && mac_done) begin
            r_sum <= mac_res;
        end
        if (r_state == tmp_pkg::ST_STORE) r_res[ij] <= r_sum;
        if (r_state == tmp_pkg::ST_NEXT) begin
            for (int e = 0; e < 9; e++) begin
                if (r_is_sq) r_sq[e] <= r_res[e];
                else         r_acc[e] <= r_res[e];
            end
        end
        if (r_state == tmp_pkg::ST_DONE) begin
            r_out <= (r_p == '0 && r_mod >= W'(2) && r_acc[1] != W'(0))
                ? r_acc[1] : '0;
        end
    end

    assign o_valid = r_valid;
    assign o_term_value = r_out;
endmodule
